// ===== src/dllm_pkg.sv =====
// Shared types and constants for the doubly linked list manager.
// No dependencies; imported by doubly_linked_list_manager_unit and the testbench.
`timescale 1ns / 1ps

package dllm_pkg;

  localparam int DEF_POOL_NODES = 256;
  localparam int NODE_W         = 8;
  localparam int CNT_W          = 9;

  // operation codes carried in the kind field
  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_REMOVE = 2'd1,
    K_POP    = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_SWEEP,   // nulling every link entry, one per cycle
    S_IDLE,    // ready for the next word
    S_LOOK,    // link read data back, decide and write first links
    S_LINK,    // second link write for remove and pop
    S_POST     // result held until the output register frees up
  } st_t;

endpackage

// ===== src/doubly_linked_list_manager_unit.sv =====
// Doubly linked list manager: next/prev link memories, head, tail and count.
// Append finishes in S_LOOK; remove and pop go on through S_LINK unless rejected,
// and clear runs a full sweep; one item in flight at a time,
// set by the single read-modify-write port of each link memory.
// Reset: synchronous; a sweep then nulls every link while
// op_stall stays high. Depends on dllm_pkg.
`timescale 1ns / 1ps

module doubly_linked_list_manager_unit #(
  parameter int POOL_NODES = dllm_pkg::DEF_POOL_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  // operation channel
  input  logic                        op_valid,
  output logic                        op_stall,
  input  dllm_pkg::kind_t             kind,
  input  logic [dllm_pkg::NODE_W-1:0] node,
  // result channel
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [dllm_pkg::NODE_W-1:0] popped_node,
  output logic                        popped_valid,
  output logic                        took_effect,
  output logic [dllm_pkg::CNT_W-1:0]  count
);
  import dllm_pkg::*;

  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = IW + 1;   // top bit is the null flag
  localparam logic [LW-1:0] LINK_NULL = {1'b1, {IW{1'b0}}};
  localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_NODES - 1);

  st_t state, state_next;

  logic [LW-1:0] next_mem [POOL_NODES];
  logic [LW-1:0] prev_mem [POOL_NODES];
  logic [LW-1:0] nx_rd, pv_rd;
  logic [IW-1:0] rd_addr;

  logic          nx_we, pv_we;
  logic [IW-1:0] nx_wa, pv_wa;
  logic [LW-1:0] nx_wd, pv_wd;

  logic [LW-1:0]    head, head_next, tail, tail_next, link_save, link_save_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  kind_t            op_kind;
  logic [IW-1:0]    op_idx;
  logic             op_ok;
  logic [IW-1:0]    sweep_idx;
  logic             clr_res, clr_took;

  logic              accept, slot_free, fin, out_load;
  logic [NODE_W-1:0] fin_pn;
  logic              fin_pv, fin_took;
  logic [NODE_W-1:0] pend_pn;
  logic              pend_pv, pend_took;
  logic [CNT_W-1:0]  pend_cnt;

  logic before_nul, after_nul, is_head, rm_ok, ap_ok;

  assign op_stall  = (state != S_IDLE);
  assign accept    = op_valid && !op_stall;
  assign slot_free = !res_valid || !res_stall;
  assign rd_addr   = (kind == K_POP) ? head[IW-1:0] : IW'(node);

  // guards, valid in S_LOOK with the link read data
  assign before_nul = pv_rd[IW];
  assign after_nul  = nx_rd[IW];
  assign is_head    = !head[IW] && (head[IW-1:0] == op_idx);
  assign rm_ok      = op_ok && !(!is_head && before_nul && after_nul);
  assign ap_ok      = op_ok && !((!tail[IW] && (tail[IW-1:0] == op_idx)) || !after_nul);

  // link memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    nx_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    pv_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      head      <= LINK_NULL;
      tail      <= LINK_NULL;
      cnt       <= '0;
      sweep_idx <= '0;
      clr_res   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      cnt   <= cnt_next;
      if (accept && kind == K_CLEAR) begin
        sweep_idx <= '0;
        clr_res   <= 1'b1;
      end else if (state == S_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
        if (sweep_idx == LAST_IDX) clr_res <= 1'b0;
      end
      if (out_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    link_save <= link_save_next;
    if (accept) begin
      op_kind  <= kind;
      op_idx   <= (kind == K_POP) ? head[IW-1:0] : IW'(node);
      op_ok    <= 32'(node) < POOL_NODES;
      clr_took <= (cnt != '0);
    end
    if (fin && !slot_free) begin
      pend_pn   <= fin_pn;
      pend_pv   <= fin_pv;
      pend_took <= fin_took;
      pend_cnt  <= cnt_next;
    end
    if (out_load) begin
      if (state == S_POST) begin
        popped_node  <= pend_pn;
        popped_valid <= pend_pv;
        took_effect  <= pend_took;
        count        <= pend_cnt;
      end else begin
        popped_node  <= fin_pn;
        popped_valid <= fin_pv;
        took_effect  <= fin_took;
        count        <= cnt_next;
      end
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    cnt_next       = cnt;
    link_save_next = link_save;
    nx_we = 1'b0;  nx_wa = op_idx;  nx_wd = LINK_NULL;
    pv_we = 1'b0;  pv_wa = op_idx;  pv_wd = LINK_NULL;
    fin      = 1'b0;
    fin_pn   = '0;
    fin_pv   = 1'b0;
    fin_took = 1'b0;

    unique case (state)
      S_SWEEP: begin
        nx_we = 1'b1;  nx_wa = sweep_idx;
        pv_we = 1'b1;  pv_wa = sweep_idx;
        if (sweep_idx == LAST_IDX) begin
          if (clr_res) begin
            fin      = 1'b1;
            fin_took = clr_took;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind == K_CLEAR) begin
            head_next  = LINK_NULL;
            tail_next  = LINK_NULL;
            cnt_next   = '0;
            state_next = S_SWEEP;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        case (op_kind)
          K_APPEND: begin
            fin = 1'b1;
            if (ap_ok) begin
              fin_took = 1'b1;
              pv_we    = 1'b1;
              if (!head[IW] && !tail[IW]) begin
                nx_we = 1'b1;
                nx_wa = tail[IW-1:0];
                nx_wd = {1'b0, op_idx};
                pv_wd = tail;
              end else begin
                head_next = {1'b0, op_idx};
              end
              tail_next = {1'b0, op_idx};
              cnt_next  = cnt + 1'b1;
            end
          end
          K_REMOVE: begin
            if (rm_ok) begin
              if (!before_nul) begin
                nx_we = 1'b1;
                nx_wa = pv_rd[IW-1:0];
                nx_wd = nx_rd;
              end else begin
                head_next = nx_rd;
              end
              if (!after_nul) begin
                pv_we = 1'b1;
                pv_wa = nx_rd[IW-1:0];
                pv_wd = pv_rd;
              end else begin
                tail_next = pv_rd;
              end
              state_next = S_LINK;
            end else begin
              fin = 1'b1;
            end
          end
          K_POP: begin
            if (cnt != '0 && !head[IW]) begin
              nx_we          = 1'b1;
              pv_we          = 1'b1;
              head_next      = nx_rd;
              link_save_next = nx_rd;
              if (after_nul) tail_next = LINK_NULL;
              state_next = S_LINK;
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_LINK: begin
        fin      = 1'b1;
        fin_took = 1'b1;
        case (op_kind)
          K_REMOVE: begin
            // unlink the removed node itself last
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (cnt != '0) cnt_next = cnt - 1'b1;
          end
          K_POP: begin
            if (!link_save[IW]) begin
              pv_we = 1'b1;
              pv_wa = link_save[IW-1:0];
            end
            cnt_next = cnt - 1'b1;
            fin_pn   = NODE_W'(op_idx);
            fin_pv   = 1'b1;
          end
          default: fin_took = 1'b0;
        endcase
      end
      S_POST: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) state_next = slot_free ? S_IDLE : S_POST;
  end

  assign out_load = slot_free && (fin || state == S_POST);

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for doubly_linked_list_manager_unit: a directed table, then random
// list traffic, each result word checked against its row or an in-bench list predictor.
// Depends on dllm_pkg and the unit under test; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
  import dllm_pkg::*;

  localparam logic [8:0] NIL = 9'h100;  // bit 8 marks an empty link
  localparam int SCRIPT_LEN = 27;

  typedef struct packed {
    logic [7:0] popped_node;
    logic       popped_valid;
    logic       took_effect;
    logic [8:0] count;
  } list_res_t;

  typedef struct packed {
    kind_t      k;
    logic [7:0] n;
    logic       chk;   // 1: the expected word is given in the row
    logic [7:0] pn;
    logic       pv;
    logic       te;
    logic [8:0] cnt;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{K_POP,    8'd0,   1'b1, 8'd0, 1'b0, 1'b0, 9'd0},  // pop on empty list after reset
    '{K_REMOVE, 8'd5,   1'b1, 8'd0, 1'b0, 1'b0, 9'd0},  // remove from empty list
    '{K_CLEAR,  8'd0,   1'b1, 8'd0, 1'b0, 1'b0, 9'd0},  // clear of empty list
    '{K_APPEND, 8'd0,   1'b1, 8'd0, 1'b0, 1'b1, 9'd1},
    '{K_APPEND, 8'd0,   1'b1, 8'd0, 1'b0, 1'b0, 9'd1},  // already the tail
    '{K_APPEND, 8'd255, 1'b1, 8'd0, 1'b0, 1'b1, 9'd2},
    '{K_APPEND, 8'd128, 1'b1, 8'd0, 1'b0, 1'b1, 9'd3},
    '{K_APPEND, 8'd255, 1'b1, 8'd0, 1'b0, 1'b0, 9'd3},  // has a successor
    '{K_REMOVE, 8'd77,  1'b1, 8'd0, 1'b0, 1'b0, 9'd3},  // not listed
    '{K_REMOVE, 8'd255, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // middle
    '{K_REMOVE, 8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // head
    '{K_REMOVE, 8'd128, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // only node left
    '{K_APPEND, 8'd170, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_APPEND, 8'd85,  1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_APPEND, 8'd3,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_REMOVE, 8'd3,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // tail
    '{K_POP,    8'd255, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // node field ignored
    '{K_POP,    8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_POP,    8'd0,   1'b1, 8'd0, 1'b0, 1'b0, 9'd0},  // drained
    '{K_APPEND, 8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_APPEND, 8'd2,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_REMOVE, 8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // head with successor
    '{K_APPEND, 8'd1,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_CLEAR,  8'd0,   1'b1, 8'd0, 1'b0, 1'b1, 9'd0},
    '{K_CLEAR,  8'd255, 1'b1, 8'd0, 1'b0, 1'b0, 9'd0},
    '{K_APPEND, 8'd2,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0},  // links usable after clear
    '{K_POP,    8'd0,   1'b0, 8'd0, 1'b0, 1'b0, 9'd0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       op_valid = 1'b0;
  logic       op_stall;
  kind_t      kind = K_APPEND;
  logic [7:0] node = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] popped_node;
  logic       popped_valid;
  logic       took_effect;
  logic [8:0] count;

  doubly_linked_list_manager_unit dut (
    .clk(clk), .rst(rst),
    .op_valid(op_valid), .op_stall(op_stall), .kind(kind), .node(node),
    .res_valid(res_valid), .res_stall(res_stall),
    .popped_node(popped_node), .popped_valid(popped_valid),
    .took_effect(took_effect), .count(count)
  );

  always #5 clk = ~clk;

  // predicted list state
  logic [8:0] nxt_ln [256];
  logic [8:0] prv_ln [256];
  logic [8:0] hd_ptr, tl_ptr;
  logic [8:0] n_listed;

  list_res_t pending_q [$];
  int        send_idle_pct, recv_idle_pct;
  int        errors = 0;
  int        n_ops = 0, n_words = 0, n_pops = 0, n_clears = 0;
  int        peak_len = 0;
  logic [3:0] hot_hi = 4'd0;

  function automatic void wipe_list();
    for (int i = 0; i < 256; i++) begin
      nxt_ln[i] = NIL;
      prv_ln[i] = NIL;
    end
    hd_ptr = NIL;
    tl_ptr = NIL;
    n_listed = 9'd0;
  endfunction

  function automatic list_res_t apply_op(kind_t k, logic [7:0] n);
    list_res_t  r;
    logic [8:0] bef, aft, nx;
    logic       hit_head;
    r = '0;
    case (k)
      K_APPEND: begin
        if (!((!tl_ptr[8] && tl_ptr[7:0] == n) || !nxt_ln[n][8])) begin
          if (!hd_ptr[8] && !tl_ptr[8]) begin
            nxt_ln[tl_ptr[7:0]] = {1'b0, n};
            prv_ln[n] = tl_ptr;
            tl_ptr = {1'b0, n};
          end else begin
            hd_ptr = {1'b0, n};
            tl_ptr = {1'b0, n};
            prv_ln[n] = NIL;
          end
          n_listed = n_listed + 9'd1;
          r.took_effect = 1'b1;
        end
      end
      K_REMOVE: begin
        bef = prv_ln[n];
        aft = nxt_ln[n];
        hit_head = !hd_ptr[8] && hd_ptr[7:0] == n;
        // unlisted: not the head and no links either way
        if (hit_head || !bef[8] || !aft[8]) begin
          if (!bef[8]) nxt_ln[bef[7:0]] = aft;
          else hd_ptr = aft;
          if (!aft[8]) prv_ln[aft[7:0]] = bef;
          else tl_ptr = bef;
          prv_ln[n] = NIL;
          nxt_ln[n] = NIL;
          if (n_listed != 9'd0) n_listed = n_listed - 9'd1;
          r.took_effect = 1'b1;
        end
      end
      K_POP: begin
        if (n_listed != 9'd0 && !hd_ptr[8]) begin
          r.popped_node = hd_ptr[7:0];
          nx = nxt_ln[r.popped_node];
          nxt_ln[r.popped_node] = NIL;
          prv_ln[r.popped_node] = NIL;
          hd_ptr = nx;
          if (!nx[8]) prv_ln[nx[7:0]] = NIL;
          else tl_ptr = NIL;
          n_listed = n_listed - 9'd1;
          r.popped_valid = 1'b1;
          r.took_effect = 1'b1;
        end
      end
      default: begin
        r.took_effect = n_listed != 9'd0;
        wipe_list();
      end
    endcase
    r.count = n_listed;
    return r;
  endfunction

  // Offer one word; the expectation is queued at the edge that accepts it.
  task automatic send_op(kind_t k, logic [7:0] n, logic chk, list_res_t want);
    list_res_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    kind     <= k;
    node     <= n;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    got = apply_op(k, n);
    pending_q.push_back(chk ? want : got);
    n_ops++;
    if (got.popped_valid) n_pops++;
    if (k == K_CLEAR && got.took_effect) n_clears++;
    if (int'(got.count) > peak_len) peak_len = int'(got.count);
  endtask

  // Mostly nodes from a small hot window so appends, removes and pops hit listed nodes.
  task automatic run_mix(int n_items);
    kind_t      k;
    logic [7:0] n;
    int         pick;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 19) == 0) hot_hi = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      k = pick < 45 ? K_APPEND : pick < 72 ? K_REMOVE : pick < 97 ? K_POP : K_CLEAR;
      if ($urandom_range(0, 3) == 0) n = 8'($urandom_range(0, 255));
      else n = {hot_hi, 4'($urandom_range(0, 15))};
      send_op(k, n, 1'b0, '0);
    end
  endtask

  task automatic report(string what, list_res_t want, list_res_t seen);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want node %0d pv %0b te %0b cnt %0d, got node %0d pv %0b te %0b cnt %0d",
               $realtime, what, want.popped_node, want.popped_valid, want.took_effect,
               want.count, seen.popped_node, seen.popped_valid, seen.took_effect, seen.count);
  endtask

  always @(posedge clk) begin
    list_res_t seen, want;
    if (!rst && res_valid && !res_stall) begin
      seen = '{popped_node, popped_valid, took_effect, count};
      if (pending_q.size() == 0) begin
        report("unexpected word", '0, seen);
      end else begin
        want = pending_q.pop_front();
        n_words++;
        if (seen !== want) report("mismatch", want, seen);
      end
    end
    res_stall <= $urandom_range(0, 99) < recv_idle_pct;
  end

  initial begin
    logic [7:0] fill_order [256];
    logic [7:0] tmp;
    int         j;
    wipe_list();
    send_idle_pct = 21;
    recv_idle_pct = 63;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_op(SCRIPT[i].k, SCRIPT[i].n, SCRIPT[i].chk,
              '{SCRIPT[i].pn, SCRIPT[i].pv, SCRIPT[i].te, SCRIPT[i].cnt});
    run_mix(180);

    send_idle_pct = 63;
    recv_idle_pct = 21;
    run_mix(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // fill the whole pool in random order to reach the full count
    for (int i = 0; i < 256; i++) fill_order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    send_op(K_CLEAR, 8'd0, 1'b0, '0);
    for (int i = 0; i < 256; i++) send_op(K_APPEND, fill_order[i], 1'b0, '0);
    run_mix(40);

    op_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d words sent, %0d result words checked, %0d pops returned a node,",
             n_ops, n_words, n_pops);
    $display("%0d clears emptied the list, peak list length %0d", n_clears, peak_len);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d errors", errors);
      $display("testbench failed");
    end
    $finish;
  end

  // every word a clear at the heaviest idling still ends well inside this
  initial begin
    #20ms;
    $display("timeout with %0d words still expected", pending_q.size());
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/dllm_pkg.sv
src/doubly_linked_list_manager_unit.sv
dv/testbench.sv
